[sv/humidity_sensor_frame_checker_defines.svh]
// assertion macros shared by the frame checker modules
`ifndef HUMIDITY_SENSOR_FRAME_CHECKER_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_CHECKER_DEFINES_SVH

// condition must hold at every edge out of reset
`define HSFC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("hsfc assertion failed");

// consequent must hold in the cycle after the antecedent
`define HSFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsfc assertion failed");

`endif

[sv/hsfc_pkg.sv]
// shared types, constants and the crc step for the frame checker
package hsfc_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // scale factors and offsets, in hundredths
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUM_SPAN    = 14'd12500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [15:0] HUM_OFFSET  = 16'd600;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    POS_T_MSB,
    POS_T_LSB,
    POS_T_CRC,
    POS_H_MSB,
    POS_H_LSB,
    POS_H_CRC
  } pos_t;

  typedef struct packed {
    logic        status;
    logic [15:0] temp_code;
    logic [15:0] hum_code;
  } frame_rec_t;

  // one byte through the crc-8, msb first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      if (c[7] ^ d[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[sv/hsfc_front.sv]
// front end: byte position tracking, crc check and word assembly
module hsfc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                frame_start,
  output logic                rec_push,
  output hsfc_pkg::frame_rec_t rec
);

  hsfc_pkg::pos_t pos;
  hsfc_pkg::pos_t pos_eff;
  hsfc_pkg::pos_t pos_next;

  logic [7:0]  running_crc;
  logic [7:0]  running_crc_next;
  logic [15:0] temp_word;
  logic [15:0] temp_word_next;
  logic [15:0] hum_word;
  logic [15:0] hum_word_next;
  logic        temp_crc_good;
  logic        temp_crc_good_next;
  logic [7:0]  crc_step;

  assign pos_eff  = frame_start ? hsfc_pkg::POS_T_MSB : pos;
  assign crc_step = hsfc_pkg::crc_feed(
    (pos_eff == hsfc_pkg::POS_T_MSB || pos_eff == hsfc_pkg::POS_H_MSB) ?
      hsfc_pkg::CRC_INIT : running_crc, data_byte);

  // next position
  always_comb begin
    case (pos_eff)
      hsfc_pkg::POS_T_MSB: pos_next = hsfc_pkg::POS_T_LSB;
      hsfc_pkg::POS_T_LSB: pos_next = hsfc_pkg::POS_T_CRC;
      hsfc_pkg::POS_T_CRC: pos_next = hsfc_pkg::POS_H_MSB;
      hsfc_pkg::POS_H_MSB: pos_next = hsfc_pkg::POS_H_LSB;
      hsfc_pkg::POS_H_LSB: pos_next = hsfc_pkg::POS_H_CRC;
      default:             pos_next = hsfc_pkg::POS_T_MSB;
    endcase
  end

  // datapath updates per position
  always_comb begin
    running_crc_next   = running_crc;
    temp_word_next     = temp_word;
    hum_word_next      = hum_word;
    temp_crc_good_next = temp_crc_good;
    rec_push           = 1'b0;
    case (pos_eff)
      hsfc_pkg::POS_T_MSB: begin
        running_crc_next = crc_step;
        temp_word_next   = {data_byte, temp_word[7:0]};
      end
      hsfc_pkg::POS_T_LSB: begin
        running_crc_next = crc_step;
        temp_word_next   = {temp_word[15:8], data_byte};
      end
      hsfc_pkg::POS_T_CRC: begin
        temp_crc_good_next = (data_byte == running_crc);
        running_crc_next   = hsfc_pkg::CRC_INIT;
      end
      hsfc_pkg::POS_H_MSB: begin
        running_crc_next = crc_step;
        hum_word_next    = {data_byte, hum_word[7:0]};
      end
      hsfc_pkg::POS_H_LSB: begin
        running_crc_next = crc_step;
        hum_word_next    = {hum_word[15:8], data_byte};
      end
      default: begin
        running_crc_next = hsfc_pkg::CRC_INIT;
        rec_push         = accept;
      end
    endcase
  end

  assign rec.status    = !(temp_crc_good && (data_byte == running_crc));
  assign rec.temp_code = temp_word;
  assign rec.hum_code  = hum_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= hsfc_pkg::POS_T_MSB;
      running_crc   <= hsfc_pkg::CRC_INIT;
      temp_word     <= '0;
      hum_word      <= '0;
      temp_crc_good <= 1'b0;
    end else if (accept) begin
      pos           <= pos_next;
      running_crc   <= running_crc_next;
      temp_word     <= temp_word_next;
      hum_word      <= hum_word_next;
      temp_crc_good <= temp_crc_good_next;
    end
  end

endmodule

[sv/hsfc_queue.sv]
// short queue of checked frames between front and back end
`include "humidity_sensor_frame_checker_defines.svh"

module hsfc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  hsfc_pkg::frame_rec_t wr_rec,
  output logic                 full,
  input  logic                 pop,
  output hsfc_pkg::frame_rec_t rd_rec,
  output logic                 empty
);

  hsfc_pkg::frame_rec_t slots [hsfc_pkg::QDEPTH];

  logic [hsfc_pkg::QPTR_W-1:0] wr_ptr;
  logic [hsfc_pkg::QPTR_W-1:0] rd_ptr;
  logic [hsfc_pkg::QCNT_W-1:0] count;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count == hsfc_pkg::QCNT_W'(hsfc_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_rec  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `HSFC_ASSERT_ALWAYS(a_count_bound, count <= hsfc_pkg::QCNT_W'(hsfc_pkg::QDEPTH))
  `HSFC_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count == $past(count) + 1'b1)

endmodule

[sv/hsfc_back.sv]
// back end: scales the raw words, two stages, result register on the output
`include "humidity_sensor_frame_checker_defines.svh"

module hsfc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  hsfc_pkg::frame_rec_t q_rec,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic                 status,
  output logic signed [14:0]   temperature_centi,
  output logic signed [14:0]   humidity_centi,
  output logic [15:0]          temperature_code,
  output logic [15:0]          humidity_code
);

  // stage 1: products
  logic        s1_v;
  logic        s1_en;
  logic        s1_status;
  logic [15:0] s1_tcode;
  logic [15:0] s1_hcode;
  logic [30:0] s1_tprod;
  logic [29:0] s1_hprod;

  // stage 2: result register
  logic        s2_v;
  logic        s2_en;

  logic [31:0] t_sum;
  logic [31:0] h_sum;
  logic [15:0] t_quo;
  logic [15:0] h_quo;
  logic [15:0] t_centi;
  logic [15:0] h_centi;

  assign s2_en = !s2_v || pop;
  assign s1_en = !s1_v || s2_en;
  assign q_pop = s1_en && !q_empty;
  assign empty = !s2_v;

  // divide by 65535: (x + (x >> 16) + 1) >> 16, exact for quotients below 2^15
  assign t_sum = {1'b0, s1_tprod} + 32'(s1_tprod[30:16]) + 32'd1;
  assign h_sum = {2'b00, s1_hprod} + 32'(s1_hprod[29:16]) + 32'd1;
  assign t_quo = t_sum[31:16];
  assign h_quo = h_sum[31:16];
  assign t_centi = t_quo - hsfc_pkg::TEMP_OFFSET;
  assign h_centi = h_quo - hsfc_pkg::HUM_OFFSET;

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_status <= q_rec.status;
      s1_tcode  <= q_rec.temp_code;
      s1_hcode  <= q_rec.hum_code;
      s1_tprod  <= 31'(q_rec.temp_code) * 31'(hsfc_pkg::TEMP_SPAN);
      s1_hprod  <= 30'(q_rec.hum_code) * 30'(hsfc_pkg::HUM_SPAN);
    end
    if (s2_en) begin
      status            <= s1_status;
      temperature_code  <= s1_tcode;
      humidity_code     <= s1_hcode;
      temperature_centi <= s1_status ? '0 : $signed(t_centi[14:0]);
      humidity_centi    <= s1_status ? '0 : $signed(h_centi[14:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v <= !q_empty;
      end
      if (s2_en) begin
        s2_v <= s1_v;
      end
    end
  end

  `HSFC_ASSERT_ALWAYS(a_err_zero, !s2_v || !status || (temperature_centi == '0 && humidity_centi == '0))
  `HSFC_ASSERT_NEXT(a_s1_hold, s1_v && !s2_en, s1_v && $stable(s1_tprod) && $stable(s1_hprod))

endmodule

[sv/humidity_sensor_frame_checker.sv]
// top level of the humidity sensor frame checker
// Takes the six response bytes of a frame (temperature word, its crc-8, humidity word,
// its crc-8) at up to one byte per clock and delivers one result per frame: status,
// scaled temperature and humidity in hundredths, and the raw words. The front end
// updates crc and words in the cycle a byte is taken; a checked frame goes into a
// two-entry queue, then through a multiply stage and a result register, where the
// result waits for pop. full rises only while the queue holds two undelivered frames;
// otherwise a byte is taken every cycle.
module humidity_sensor_frame_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte,
  input  logic                frame_start,
  output logic                empty,
  input  logic                pop,
  output logic                status,
  output logic signed [14:0]  temperature_centi,
  output logic signed [14:0]  humidity_centi,
  output logic [15:0]         temperature_code,
  output logic [15:0]         humidity_code
);

  logic                 accept;
  logic                 rec_push;
  hsfc_pkg::frame_rec_t front_rec;
  hsfc_pkg::frame_rec_t q_rec;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  hsfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .rec_push    (rec_push),
    .rec         (front_rec)
  );

  hsfc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (rec_push),
    .wr_rec (front_rec),
    .full   (q_full),
    .pop    (q_pop),
    .rd_rec (q_rec),
    .empty  (q_empty)
  );

  hsfc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .q_rec             (q_rec),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .status            (status),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .temperature_code  (temperature_code),
    .humidity_code     (humidity_code)
  );

endmodule

[test/tb_humidity_sensor_frame_checker.sv]
// testbench for the humidity sensor frame checker: directed and random frames, predicted results
module tb_humidity_sensor_frame_checker;

  localparam int RANDOM_REQUESTS = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_REPORTS     = 10;

  localparam logic [7:0] CRC_SEED      = 8'hFF;
  localparam logic [7:0] CRC_POLY_BITS = 8'h31;

  localparam logic [2:0] AT_T_MSB = 3'd0;
  localparam logic [2:0] AT_T_LSB = 3'd1;
  localparam logic [2:0] AT_T_CRC = 3'd2;
  localparam logic [2:0] AT_H_MSB = 3'd3;
  localparam logic [2:0] AT_H_LSB = 3'd4;
  localparam logic [2:0] AT_H_CRC = 3'd5;

  typedef enum logic [1:0] {BK_LITERAL, BK_CRC_GOOD, BK_CRC_BAD} byte_kind_e;

  typedef struct packed {
    logic               status;
    logic signed [14:0] temp_c;
    logic signed [14:0] hum_c;
    logic [15:0]        temp_code;
    logic [15:0]        hum_code;
  } reading_t;

  typedef struct {
    logic       fs;
    byte_kind_e kind;
    logic [7:0] val;
    logic       typed;
    reading_t   want;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [7:0]         data_byte;
  logic               frame_start;
  logic               empty;
  logic               pop;
  logic               status;
  logic signed [14:0] temperature_centi;
  logic signed [14:0] humidity_centi;
  logic [15:0]        temperature_code;
  logic [15:0]        humidity_code;

  humidity_sensor_frame_checker dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .frame_start(frame_start),
    .empty(empty),
    .pop(pop),
    .status(status),
    .temperature_centi(temperature_centi),
    .humidity_centi(humidity_centi),
    .temperature_code(temperature_code),
    .humidity_code(humidity_code)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // frame decoder state as the block should hold it
  logic [2:0]  model_pos = AT_T_MSB;
  logic [7:0]  model_crc = CRC_SEED;
  logic [15:0] model_temp_word = '0;
  logic [15:0] model_hum_word = '0;
  logic        model_temp_ok = 1'b0;

  reading_t  pending_results[$];
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        bytes_sent = 0;
  int        stall_cycles = 0;
  logic      sender_steady = 1'b0;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY_BITS : 8'h00);
    end
    return c;
  endfunction

  function automatic logic signed [14:0] scale_centi(input logic [15:0] code,
                                                     input int unsigned span,
                                                     input int offset);
    int unsigned prod;
    int          v;
    prod = span * {16'h0000, code};
    v = prod / 32'd65535;
    v = v - offset;
    return v[14:0];
  endfunction

  // one request through the decoder; got is set when the byte closes a frame
  function automatic void decode_byte(input logic fs, input logic [7:0] b,
                                      output logic got, output reading_t r);
    logic [2:0] pos;
    logic       hum_ok;
    got = 1'b0;
    r = '0;
    pos = (fs || model_pos > AT_H_CRC) ? AT_T_MSB : model_pos;
    case (pos)
      AT_T_MSB: begin
        model_crc = crc8_step(CRC_SEED, b);
        model_temp_word[15:8] = b;
      end
      AT_T_LSB: begin
        model_crc = crc8_step(model_crc, b);
        model_temp_word[7:0] = b;
      end
      AT_T_CRC: begin
        model_temp_ok = (b == model_crc);
        model_crc = CRC_SEED;
      end
      AT_H_MSB: begin
        model_crc = crc8_step(CRC_SEED, b);
        model_hum_word[15:8] = b;
      end
      AT_H_LSB: begin
        model_crc = crc8_step(model_crc, b);
        model_hum_word[7:0] = b;
      end
      default: ;
    endcase
    if (pos != AT_H_CRC) begin
      model_pos = pos + 3'd1;
    end else begin
      hum_ok = (b == model_crc);
      got = 1'b1;
      r.status = !(model_temp_ok && hum_ok);
      if (!r.status) begin
        r.temp_c = scale_centi(model_temp_word, 17500, 4500);
        r.hum_c = scale_centi(model_hum_word, 12500, 600);
      end
      r.temp_code = model_temp_word;
      r.hum_code = model_hum_word;
      model_pos = AT_T_MSB;
      model_crc = CRC_SEED;
    end
  endfunction

  function automatic reading_t reading(input logic st, input int t, input int h,
                                       input logic [15:0] tc, input logic [15:0] hc);
    reading_t r;
    r.status = st;
    r.temp_c = t[14:0];
    r.hum_c = h[14:0];
    r.temp_code = tc;
    r.hum_code = hc;
    return r;
  endfunction

  function automatic string describe(input reading_t r);
    return $sformatf("status %0d temp %0d hum %0d tcode %h hcode %h",
                     r.status, r.temp_c, r.hum_c, r.temp_code, r.hum_code);
  endfunction

  function automatic void add_row(input logic fs, input byte_kind_e k, input logic [7:0] v);
    stim_row_t row;
    row.fs = fs;
    row.kind = k;
    row.val = v;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_last(input logic fs, input byte_kind_e k, input reading_t want);
    stim_row_t row;
    row.fs = fs;
    row.kind = k;
    row.val = 8'h00;
    row.typed = 1'b1;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(255));
      3: return 16'hFFFF - 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic offer_byte(input logic fs, input logic [7:0] b, input logic typed,
                            input reading_t want);
    logic     got;
    reading_t r;
    push <= 1'b1;
    data_byte <= b;
    frame_start <= fs;
    do @(posedge clk); while (full);
    decode_byte(fs, b, got, r);
    if (got) begin
      pending_results.push_back(typed ? want : r);
    end
    bytes_sent++;
  endtask

  task automatic sender_gap();
    while (!sender_steady && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    push <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_frame(input logic lead_fs, input int n_bytes, input logic bad_t,
                            input logic bad_h, input logic [15:0] tw, input logic [15:0] hw);
    logic [7:0] b;
    for (int i = 0; i < n_bytes; i++) begin
      case (i)
        0: b = tw[15:8];
        1: b = tw[7:0];
        2: b = model_crc ^ (bad_t ? 8'($urandom_range(255, 1)) : 8'h00);
        3: b = hw[15:8];
        4: b = hw[7:0];
        default: b = model_crc ^ (bad_h ? 8'($urandom_range(255, 1)) : 8'h00);
      endcase
      offer_byte((i == 0) ? lead_fs : 1'b0, b, 1'b0, '0);
      sender_gap();
    end
  endtask

  task automatic check_reading();
    reading_t seen;
    reading_t want;
    seen = {status, temperature_centi, humidity_centi, temperature_code, humidity_code};
    results_seen++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("unexpected result: %s", describe(seen));
      end
    end else begin
      want = pending_results.pop_front();
      if (seen !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d differs", results_seen);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(seen));
        end
      end
    end
  endtask

  // result side: random stalls, one long hold-off, one stretch with no stalls
  initial begin
    int   hold_left;
    logic held;
    hold_left = 0;
    held = 1'b0;
    pop = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        check_reading();
      end
      if (!held && results_seen == 20) begin
        held = 1'b1;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= (results_seen >= 40 && results_seen < 56) || ($urandom_range(99) >= 26);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [7:0] b;
    int         target;
    int         sel;
    logic       paused;
    rst = 1'b1;
    push = 1'b0;
    data_byte = 8'h00;
    frame_start = 1'b0;
    paused = 1'b0;

    // all-zero words with good crcs give the lowest scaled values
    add_row(1'b1, BK_LITERAL, 8'h00);
    add_row(1'b0, BK_LITERAL, 8'h00);
    add_row(1'b0, BK_CRC_GOOD, 8'h00);
    add_row(1'b0, BK_LITERAL, 8'h00);
    add_row(1'b0, BK_LITERAL, 8'h00);
    add_last(1'b0, BK_CRC_GOOD, reading(1'b0, -4500, -600, 16'h0000, 16'h0000));
    // no frame_start after a frame end, top codes
    add_row(1'b0, BK_LITERAL, 8'hFF);
    add_row(1'b0, BK_LITERAL, 8'hFF);
    add_row(1'b0, BK_CRC_GOOD, 8'h00);
    add_row(1'b0, BK_LITERAL, 8'hFF);
    add_row(1'b0, BK_LITERAL, 8'hFF);
    add_last(1'b0, BK_CRC_GOOD, reading(1'b0, 13000, 11900, 16'hFFFF, 16'hFFFF));
    // restart mid-frame drops the partial one; then a bad temperature crc
    add_row(1'b1, BK_LITERAL, 8'hBE);
    add_row(1'b0, BK_LITERAL, 8'hEF);
    add_row(1'b1, BK_LITERAL, 8'h12);
    add_row(1'b0, BK_LITERAL, 8'h34);
    add_row(1'b0, BK_CRC_BAD, 8'h00);
    add_row(1'b0, BK_LITERAL, 8'h56);
    add_row(1'b0, BK_LITERAL, 8'h78);
    add_last(1'b0, BK_CRC_GOOD, reading(1'b1, 0, 0, 16'h1234, 16'h5678));
    // only the humidity crc wrong
    add_row(1'b1, BK_LITERAL, 8'hA5);
    add_row(1'b0, BK_LITERAL, 8'h5A);
    add_row(1'b0, BK_CRC_GOOD, 8'h00);
    add_row(1'b0, BK_LITERAL, 8'hC3);
    add_row(1'b0, BK_LITERAL, 8'h3C);
    add_last(1'b0, BK_CRC_BAD, reading(1'b1, 0, 0, 16'hA55A, 16'hC33C));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        BK_CRC_GOOD: b = model_crc;
        BK_CRC_BAD:  b = model_crc ^ 8'h01;
        default:     b = directed_rows[i].val;
      endcase
      offer_byte(directed_rows[i].fs, b, directed_rows[i].typed, directed_rows[i].want);
      sender_gap();
    end
    wait_for_drain();

    target = bytes_sent + RANDOM_REQUESTS;
    while (bytes_sent < target) begin
      sender_steady = (bytes_sent >= 320 && bytes_sent < 400);
      if (!paused && bytes_sent >= 250) begin
        paused = 1'b1;
        wait_for_drain();
      end
      sel = $urandom_range(99);
      if (sel < 80) begin
        send_frame((model_pos == AT_T_MSB) ? 1'($urandom_range(1)) : 1'b1, 6,
                   $urandom_range(7) == 0, $urandom_range(7) == 0, pick_word(), pick_word());
      end else if (sel < 90) begin
        // truncated frame, dropped by the next frame_start
        send_frame(1'b1, $urandom_range(5, 1), 1'b0, 1'b0, pick_word(), pick_word());
      end else begin
        repeat ($urandom_range(4, 1)) begin
          offer_byte($urandom_range(3) == 0, 8'($urandom), 1'b0, '0);
          sender_gap();
        end
      end
    end
    sender_steady = 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
